// ===== rtl/mssa_pkg.sv =====
// ----------------------------------------------------------------------------
// mssa_pkg
// Shared types and constants for the multi-stack shared array block.
// ----------------------------------------------------------------------------
package mssa_pkg;

   localparam int NUM_STACKS_DEF  = 4;
   localparam int NUM_ENTRIES_DEF = 8;

   typedef enum logic {
      ACTION_PUSH = 1'b0,
      ACTION_POP  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [1:0]         stack_id;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] popped_value;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;   // reset pass over link and top stores
      logic accept;     // latch the incoming request
      logic fetch;      // read stack top (and free-head link)
      logic walk;       // pop: read link and data at the top entry
      logic exec;       // update stores, produce response
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_pop;
   } dp_stat_type;

endpackage

// ===== rtl/mssa_ram.sv =====
// ----------------------------------------------------------------------------
// mssa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mssa_ctrl.sv =====
// ----------------------------------------------------------------------------
// mssa_ctrl
// Sequencer: reset clearing pass, then fetch / walk / execute per request.
// ----------------------------------------------------------------------------
module mssa_ctrl
   import mssa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type dp_stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_WALK,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (dp_stat.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_FETCH;
                  busy_ff  <= 1'b1;
               end
            end
            ST_FETCH: begin
               state_ff <= dp_stat.is_pop ? ST_WALK : ST_EXEC;
            end
            ST_WALK: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_CLEAR;
               busy_ff  <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.clear_en = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) && start;
      cmd.fetch    = (state_ff == ST_FETCH);
      cmd.walk     = (state_ff == ST_WALK);
      cmd.exec     = (state_ff == ST_EXEC);
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/mssa_dp.sv =====
// ----------------------------------------------------------------------------
// mssa_dp
// Datapath: data, link and top stores, free-list head, response register.
// ----------------------------------------------------------------------------
module mssa_dp
   import mssa_pkg::*;
#(
   parameter int NUM_STACKS  = NUM_STACKS_DEF,
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int PTR_W    = $clog2(NUM_ENTRIES + 1);      // holds the end mark
   localparam int IDX_W    = $clog2(NUM_ENTRIES);
   localparam int STACK_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CLR_N    = (NUM_ENTRIES > NUM_STACKS) ? NUM_ENTRIES : NUM_STACKS;
   localparam int CNT_W    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
   localparam logic [PTR_W-1:0] END_MARK = PTR_W'(NUM_ENTRIES);

   req_type          req_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] clr_cnt_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [PTR_W-1:0]    top_rd, link_rd;
   logic [31:0]         data_rd;
   logic                sid_ok, head_ok, top_ok, is_pop;
   logic [STACK_AW-1:0] sid_addr;
   logic [IDX_W-1:0]    head_idx, top_idx;
   logic                push_ok, pop_ok;
   logic                clr_link, clr_top;

   logic                top_we, link_we, data_we, link_re;
   logic [STACK_AW-1:0] top_waddr;
   logic [PTR_W-1:0]    top_wdata, link_wdata;
   logic [IDX_W-1:0]    link_waddr, link_raddr;

   always_comb begin
      is_pop   = (req_ff.action == ACTION_POP);
      sid_ok   = (int'(req_ff.stack_id) < NUM_STACKS);
      sid_addr = sid_ok ? STACK_AW'(req_ff.stack_id) : '0;
      head_ok  = (head_ff < END_MARK);
      head_idx = head_ok ? IDX_W'(head_ff) : '0;
      top_ok   = (top_rd < END_MARK);
      top_idx  = top_ok ? IDX_W'(top_rd) : '0;
      push_ok  = cmd.exec && !is_pop && sid_ok && head_ok;
      pop_ok   = cmd.exec && is_pop && sid_ok && top_ok;
      clr_link = cmd.clear_en && ({1'b0, clr_cnt_ff} < (CNT_W + 1)'(NUM_ENTRIES));
      clr_top  = cmd.clear_en && ({1'b0, clr_cnt_ff} < (CNT_W + 1)'(NUM_STACKS));
   end

   // store write muxing: clearing pass, push, pop
   always_comb begin
      top_we     = clr_top || push_ok || pop_ok;
      top_waddr  = cmd.clear_en ? STACK_AW'(clr_cnt_ff) : sid_addr;
      top_wdata  = cmd.clear_en ? END_MARK : (push_ok ? head_ff : link_rd);

      link_we    = clr_link || push_ok || pop_ok;
      link_waddr = cmd.clear_en ? IDX_W'(clr_cnt_ff) : (push_ok ? head_idx : top_idx);
      link_wdata = cmd.clear_en ? (PTR_W'(clr_cnt_ff) + PTR_W'(1))
                                : (push_ok ? top_rd : head_ff);
      link_re    = cmd.fetch || cmd.walk;
      link_raddr = cmd.walk ? top_idx : head_idx;

      data_we    = push_ok;
   end

   always_comb begin
      head_in = head_ff;
      if (push_ok) begin
         head_in = link_rd;
      end else if (pop_ok) begin
         head_in = top_rd;
      end

      rsp_in = '0;
      if (!is_pop) begin
         rsp_in.status = push_ok ? STATUS_DONE : STATUS_OVERFLOW;
      end else if (sid_ok && top_ok) begin
         rsp_in.status       = STATUS_DONE;
         rsp_in.popped_value = data_rd;
      end else begin
         rsp_in.status       = STATUS_UNDERFLOW;
         rsp_in.popped_value = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= cmd.exec;
         if (cmd.clear_en) begin
            clr_cnt_ff <= clr_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   mssa_ram #(.WIDTH(PTR_W), .DEPTH(NUM_STACKS)) u_top_ram (
      .clock (clock),
      .we    (top_we),
      .waddr (top_waddr),
      .wdata (top_wdata),
      .re    (cmd.fetch),
      .raddr (sid_addr),
      .rdata (top_rd)
   );

   mssa_ram #(.WIDTH(PTR_W), .DEPTH(NUM_ENTRIES)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rd)
   );

   mssa_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (head_idx),
      .wdata (req_ff.value),
      .re    (cmd.walk),
      .raddr (top_idx),
      .rdata (data_rd)
   );

   assign dp_stat.clear_last = (clr_cnt_ff == CNT_W'(CLR_N - 1));
   assign dp_stat.is_pop     = is_pop;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

endmodule

// ===== rtl/multi_stack_shared_array.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_array
// Several LIFO stacks sharing one entry pool, unused entries on a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: drive req_data (action, stack_id, value) and raise start; the
//   request is taken at a clock edge where start is high and busy is low.
//   Push takes the free-list head entry, pop returns the top entry to the
//   free list.
//   Responses: rsp_data (status, popped_value) is valid for exactly one cycle
//   while rsp_valid is high. The receiver cannot stall; it must take it.
//   Sequencing: a push steps through FETCH and EXEC, a pop through FETCH,
//   WALK and EXEC; the response is registered from EXEC. The next request
//   can be taken in the response cycle. The pop needs WALK because the link and
//   data reads are addressed by the top pointer, itself a registered RAM read.
//   Reset: synchronous. Afterward a clearing pass writes the link store
//   (entry i -> i+1) and the top store (all empty), one entry per cycle;
//   busy stays high during that pass.
//   Overflow (pool full / bad stack) and underflow (empty / bad stack) leave
//   all state untouched.
// ----------------------------------------------------------------------------
module multi_stack_shared_array
   import mssa_pkg::*;
#(
   parameter int NUM_STACKS  = NUM_STACKS_DEF,
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type dp_stat;

   // sequencer: owns busy and steps each request through its read phases
   mssa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .dp_stat (dp_stat),
      .cmd     (cmd)
   );

   // stores, free-list head and the response register
   mssa_dp #(
      .NUM_STACKS  (NUM_STACKS),
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/mssa_checker.sv =====
// ----------------------------------------------------------------------------
// mssa_checker
// Port-level checks on request/response timing of the shared-array stacks.
// ----------------------------------------------------------------------------
module mssa_checker
   import mssa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic take;
   assign take = start && !busy;

   // push answers with a zero value
   a_push_rsp: assert property (@(posedge clock) disable iff (reset)
      take && (req_data.action == ACTION_PUSH) |->
         ##3 (rsp_valid && (rsp_data.popped_value == '0)))
      else $error("push response missing or nonzero value");

   // every taken pop gets a response
   a_pop_rsp: assert property (@(posedge clock) disable iff (reset)
      take && (req_data.action == ACTION_POP) |-> ##4 rsp_valid)
      else $error("pop response missing");

   // response strobe is never high back to back
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held");

   // underflow reports -1
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_UNDERFLOW) |->
         (rsp_data.popped_value == '1))
      else $error("underflow value not -1");

endmodule

bind multi_stack_shared_array mssa_checker u_mssa_checker (.*);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_stack_shared_array. A shadow model of the
// shared pool (data words, next links, stack heads, free-list head) predicts
// every response. Directed requests cover empty pops, a full pool, extreme
// words and free-list reuse. Random phases then vary the push/pop mix, the
// stack focus and the request spacing.
// ----------------------------------------------------------------------------
module tb_top;
   import mssa_pkg::*;

   localparam int END_MARK    = NUM_ENTRIES_DEF;   // "no entry" link value
   localparam int RANDOM_REQS = 1650;

   // -------------------------------------------------------------------------
   // Shadow of the pool plus the queue of responses still owed by the block.
   // -------------------------------------------------------------------------
   class stack_scoreboard;
      logic [31:0] entry_word [NUM_ENTRIES_DEF];
      logic [3:0]  entry_next [NUM_ENTRIES_DEF];
      logic [3:0]  stack_head [NUM_STACKS_DEF];
      logic [3:0]  free_head;
      rsp_type     owed [$];
      int          errors, checked;
      int          n_push, n_pop, n_overflow, n_underflow;

      function new();
         for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
            entry_word[i] = '0;
            entry_next[i] = 4'(i + 1);
         end
         for (int s = 0; s < NUM_STACKS_DEF; s++)
            stack_head[s] = 4'(END_MARK);
         free_head = '0;
      endfunction

      // Called at the edge where a request is taken.
      function void note_request(req_type r);
         rsp_type    want;
         logic [3:0] idx;
         logic [2:0] slot;
         want.popped_value = '0;
         want.status       = STATUS_DONE;
         if (r.action == ACTION_PUSH) begin
            n_push++;
            idx = free_head;
            if (int'(r.stack_id) >= NUM_STACKS_DEF || idx >= END_MARK) begin
               want.status = STATUS_OVERFLOW;
               n_overflow++;
            end else begin
               slot                   = idx[2:0];
               free_head              = entry_next[slot];
               entry_word[slot]       = r.value;
               entry_next[slot]       = stack_head[r.stack_id];
               stack_head[r.stack_id] = idx;
            end
         end else begin
            n_pop++;
            idx = (int'(r.stack_id) < NUM_STACKS_DEF) ? stack_head[r.stack_id]
                                                      : 4'(END_MARK);
            if (idx >= END_MARK) begin
               want.status       = STATUS_UNDERFLOW;
               want.popped_value = -32'sd1;
               n_underflow++;
            end else begin
               slot                   = idx[2:0];
               stack_head[r.stack_id] = entry_next[slot];
               entry_next[slot]       = free_head;
               free_head              = idx;
               want.popped_value      = entry_word[slot];
            end
         end
         owed.push_back(want);
      endfunction

      // Called at the edge that ends a response cycle.
      function void check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response with none pending: status %0d value %h",
                        got.status, got.popped_value);
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.status !== want.status || got.popped_value !== want.popped_value) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response %0d: status exp %0d got %0d, value exp %h got %h",
                        checked, want.status, got.status, want.popped_value,
                        got.popped_value);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   always #1 clock = ~clock;

   multi_stack_shared_array uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   stack_scoreboard sb = new();

   // Response monitor: rsp_valid is sampled at the edge closing its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   bit start_held;   // start currently driven high
   bit burst_mode;   // phase with back-to-back requests
   int sent;

   function automatic req_type make_req(action_type a, logic [1:0] sid,
                                        logic [31:0] v);
      req_type r;
      r.action   = a;
      r.stack_id = sid;
      r.value    = v;
      return r;
   endfunction

   function automatic int draw_gap();
      if (burst_mode) return 0;
      return (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
   endfunction

   // extremes now and then, otherwise a full random word
   function automatic logic [31:0] draw_word();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Hold the request until taken (start high, busy low at an edge), then
   // idle for a random number of cycles.
   task automatic send_request(req_type r);
      int gap;
      if (!start_held) begin
         start      <= 1'b1;
         start_held  = 1'b1;
      end
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      sent++;
      gap = draw_gap();
      if (gap > 0) begin
         start      <= 1'b0;
         start_held  = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending until every owed response is back.
   task automatic drain();
      if (start_held) begin
         start      <= 1'b0;
         start_held  = 1'b0;
      end
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Directed part: empty pops, fill the pool, overflow, LIFO order, reuse.
   // -------------------------------------------------------------------------
   task automatic run_directed();
      for (int s = 0; s < NUM_STACKS_DEF; s++)
         send_request(make_req(ACTION_POP, 2'(s), 32'h1234_5678));
      send_request(make_req(ACTION_PUSH, 2'd0, 32'h7FFF_FFFF));
      send_request(make_req(ACTION_PUSH, 2'd1, 32'h8000_0000));
      send_request(make_req(ACTION_PUSH, 2'd2, 32'hFFFF_FFFF));
      send_request(make_req(ACTION_PUSH, 2'd3, 32'h0000_0000));
      send_request(make_req(ACTION_PUSH, 2'd0, 32'hAAAA_AAAA));
      send_request(make_req(ACTION_PUSH, 2'd0, 32'h5555_5555));
      send_request(make_req(ACTION_PUSH, 2'd3, 32'h0000_0001));
      send_request(make_req(ACTION_PUSH, 2'd1, 32'h8000_0001));
      // pool is full now
      send_request(make_req(ACTION_PUSH, 2'd2, 32'hDEAD_BEEF));
      repeat (3) send_request(make_req(ACTION_POP, 2'd0, 32'hFFFF_FFFF));
      send_request(make_req(ACTION_POP, 2'd0, 32'h0));
      // freed entry goes back out through the free list
      send_request(make_req(ACTION_PUSH, 2'd2, 32'h0F0F_F0F0));
      send_request(make_req(ACTION_POP, 2'd1, 32'h0));
      send_request(make_req(ACTION_POP, 2'd3, 32'h0));
      send_request(make_req(ACTION_POP, 2'd2, 32'h0));
      send_request(make_req(ACTION_POP, 2'd2, 32'h0));
   endtask

   // -------------------------------------------------------------------------
   // Random phases: each has its own push share, stack focus and spacing, so
   // the pool swings between empty and full and overflow/underflow both hit.
   // -------------------------------------------------------------------------
   task automatic run_random();
      int          phase_len, push_pct, focus_id, start_count;
      bit          focused;
      action_type  act;
      logic [1:0]  sid;
      start_count = sent;
      while (sent - start_count < RANDOM_REQS) begin
         phase_len  = $urandom_range(16, 96);
         case ($urandom_range(0, 4))
            0:       push_pct = 10;
            1:       push_pct = 35;
            2:       push_pct = 50;
            3:       push_pct = 65;
            default: push_pct = 90;
         endcase
         focused    = 1'($urandom_range(0, 1));
         focus_id   = $urandom_range(0, NUM_STACKS_DEF - 1);
         burst_mode = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < phase_len; i++) begin
            act = ($urandom_range(0, 99) < push_pct) ? ACTION_PUSH : ACTION_POP;
            sid = (focused && $urandom_range(0, 4) != 0) ? 2'(focus_id)
                                                         : 2'($urandom_range(0, 3));
            send_request(make_req(act, sid, draw_word()));
         end
         if ($urandom_range(0, 2) == 0)
            drain();
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain();            // full stop at least once
      run_random();
      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d requests: %0d pushes (%0d overflow), %0d pops (%0d underflow).",
               sent, sb.n_push, sb.n_overflow, sb.n_pop, sb.n_underflow);
      $display("Checked %0d responses, %0d errors, %0d still pending.",
               sb.checked, sb.errors, sb.owed.size());
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of ~1700 requests.
   initial begin
      #400000;
      $display("Timeout with %0d responses pending.", sb.owed.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
